// ===== design/integer_to_radix_ascii_top_assert.svh =====
// ----------------------------------------------------------------------------
// integer_to_radix_ascii_top_assert.svh
// Assertion macros for the radix text converter.
// ----------------------------------------------------------------------------
`ifndef INTEGER_TO_RADIX_ASCII_TOP_ASSERT_SVH
`define INTEGER_TO_RADIX_ASCII_TOP_ASSERT_SVH

`ifndef SYNTH

`define ITOA_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("itoa assertion failed");

`define ITOA_NEVER(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("itoa forbidden condition seen");

`else

`define ITOA_ASSERT(label, clk, rst_n, prop)
`define ITOA_NEVER(label, clk, rst_n, expr)

`endif

`endif

// ===== design/itoa_pkg.sv =====
// ----------------------------------------------------------------------------
// itoa_pkg
// Shared constants, types and the digit to character map.
// ----------------------------------------------------------------------------
package itoa_pkg;

	localparam int VALUE_WIDTH_DEF = 32;
	localparam int MAX_DIGITS_DEF  = 32;
	localparam int QUEUE_DEPTH     = 2;

	localparam int RADIX_W = 6;
	localparam int CHAR_W  = 7;

	localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
	localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;

	localparam logic [CHAR_W-1:0] MINUS_CHAR  = 7'h2D;
	localparam logic [CHAR_W-1:0] ZERO_CHAR   = 7'h30;
	localparam logic [CHAR_W-1:0] ALPHA_CHAR  = 7'h61;
	localparam logic [RADIX_W-1:0] DEC_DIGITS = 6'd10;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
		logic [CHAR_W-1:0] c;
		if (d < DEC_DIGITS) begin
			c = ZERO_CHAR + {1'b0, d};
		end else begin
			c = ALPHA_CHAR + {1'b0, d - DEC_DIGITS};
		end
		return c;
	endfunction

endpackage

// ===== design/itoa_ram.sv =====
// ----------------------------------------------------------------------------
// itoa_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module itoa_ram #(
	parameter int WIDTH = 6,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== design/itoa_queue.sv =====
// ----------------------------------------------------------------------------
// itoa_queue
// Short request queue between the front and back ends.
// ----------------------------------------------------------------------------
module itoa_queue
	import itoa_pkg::*;
#(
	parameter int WIDTH = 33,
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output q_status_t        status
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] entry_q [DEPTH];
	logic [PW-1:0]    wptr_q;
	logic [PW-1:0]    rptr_q;
	logic [CW-1:0]    count_q;

	assign status.full  = (count_q == CW'(DEPTH));
	assign status.empty = (count_q == '0);
	assign pop_data     = entry_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== design/itoa_front.sv =====
// ----------------------------------------------------------------------------
// itoa_front
// Radix register, request acceptance and sign / magnitude split.
// ----------------------------------------------------------------------------
module itoa_front
	import itoa_pkg::*;
#(
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [VALUE_WIDTH-1:0] number,
	output logic                   busy,
	input  logic                   cfg_valid,
	input  logic [RADIX_W-1:0]     cfg_data,
	output logic                   cfg_ready,
	input  q_status_t              q_status,
	output logic                   push,
	output logic [VALUE_WIDTH:0]   push_data,
	output logic [RADIX_W-1:0]     radix
);

	logic [RADIX_W-1:0]     radix_q;
	logic [RADIX_W-1:0]     radix_clamped;
	logic                   neg;
	logic [VALUE_WIDTH-1:0] mag;

	assign cfg_ready = 1'b1;
	assign busy      = q_status.full;
	assign push      = start && !q_status.full;
	assign radix     = radix_q;

	// most negative value stays as its own unsigned magnitude
	assign neg       = number[VALUE_WIDTH-1];
	assign mag       = neg ? (~number + 1'b1) : number;
	assign push_data = {neg, mag};

	always_comb begin
		radix_clamped = cfg_data;
		if (cfg_data < RADIX_MIN) begin
			radix_clamped = RADIX_MIN;
		end else if (cfg_data > RADIX_MAX) begin
			radix_clamped = RADIX_MAX;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= RADIX_RESET;
		end else if (cfg_valid && cfg_ready) begin
			radix_q <= radix_clamped;
		end
	end

endmodule

// ===== design/itoa_back.sv =====
// ----------------------------------------------------------------------------
// itoa_back
// Bit-serial digit divider, digit store and character sequencer.
// ----------------------------------------------------------------------------
module itoa_back
	import itoa_pkg::*;
#(
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
	parameter int MAX_DIGITS  = MAX_DIGITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  q_status_t              q_status,
	input  logic [VALUE_WIDTH:0]   pop_data,
	output logic                   pop,
	input  logic [RADIX_W-1:0]     radix,
	output logic                   strobe,
	output logic [CHAR_W-1:0]      ascii_char,
	output logic                   last_char
);

	`include "integer_to_radix_ascii_top_assert.svh"

	localparam int AW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
	localparam int CW = $clog2(MAX_DIGITS + 1);
	localparam int BW = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_SIGN,
		ST_RD,
		ST_EMIT
	} state_t;

	state_t                 state_q;
	logic [VALUE_WIDTH-1:0] quot_q;
	logic [RADIX_W-1:0]     rem_q;
	logic [BW-1:0]          bit_q;
	logic [CW-1:0]          cnt_q;
	logic [CW-1:0]          idx_q;
	logic                   neg_q;
	logic                   strobe_q;
	logic [CHAR_W-1:0]      char_q;
	logic                   last_q;

	logic [RADIX_W:0]       rem_sh;
	logic                   ge;
	logic [RADIX_W:0]       rem_new;
	logic [VALUE_WIDTH-1:0] quot_new;
	logic [CW-1:0]          cnt_next;
	logic                   digit_done;
	logic                   ram_we;
	logic                   ram_re;
	logic [AW-1:0]          ram_raddr;
	logic [RADIX_W-1:0]     ram_rdata;

	// one quotient bit per cycle, restoring
	assign rem_sh     = {rem_q, quot_q[VALUE_WIDTH-1]};
	assign ge         = (rem_sh >= {1'b0, radix});
	assign rem_new    = ge ? (rem_sh - {1'b0, radix}) : rem_sh;
	assign quot_new   = {quot_q[VALUE_WIDTH-2:0], ge};
	assign cnt_next   = cnt_q + 1'b1;
	assign digit_done = (state_q == ST_DIV) && (bit_q == BW'(VALUE_WIDTH - 1));

	assign pop       = (state_q == ST_IDLE) && !q_status.empty;
	assign ram_we    = digit_done;
	assign ram_re    = (state_q == ST_RD);
	assign ram_raddr = AW'(idx_q - 1'b1);

	assign strobe     = strobe_q;
	assign ascii_char = char_q;
	assign last_char  = last_q;

	itoa_ram #(
		.WIDTH (RADIX_W),
		.DEPTH (MAX_DIGITS)
	) u_digits (
		.clk   (clk),
		.we    (ram_we),
		.waddr (cnt_q[AW-1:0]),
		.wdata (rem_new[RADIX_W-1:0]),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			quot_q   <= '0;
			rem_q    <= '0;
			bit_q    <= '0;
			cnt_q    <= '0;
			idx_q    <= '0;
			neg_q    <= 1'b0;
			strobe_q <= 1'b0;
			char_q   <= '0;
			last_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					strobe_q <= 1'b0;
					last_q   <= 1'b0;
					if (!q_status.empty) begin
						neg_q   <= pop_data[VALUE_WIDTH];
						quot_q  <= pop_data[VALUE_WIDTH-1:0];
						rem_q   <= '0;
						bit_q   <= '0;
						cnt_q   <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					strobe_q <= 1'b0;
					last_q   <= 1'b0;
					quot_q   <= quot_new;
					if (digit_done) begin
						cnt_q <= cnt_next;
						rem_q <= '0;
						bit_q <= '0;
						if ((quot_new == '0) || (cnt_next >= CW'(MAX_DIGITS))) begin
							idx_q   <= cnt_next;
							state_q <= neg_q ? ST_SIGN : ST_RD;
						end
					end else begin
						rem_q <= rem_new[RADIX_W-1:0];
						bit_q <= bit_q + 1'b1;
					end
				end
				ST_SIGN: begin
					strobe_q <= 1'b1;
					last_q   <= 1'b0;
					char_q   <= MINUS_CHAR;
					state_q  <= ST_RD;
				end
				ST_RD: begin
					strobe_q <= 1'b0;
					last_q   <= 1'b0;
					state_q  <= ST_EMIT;
				end
				ST_EMIT: begin
					strobe_q <= 1'b1;
					char_q   <= digit_char(ram_rdata);
					last_q   <= (idx_q == CW'(1));
					idx_q    <= idx_q - 1'b1;
					state_q  <= (idx_q == CW'(1)) ? ST_IDLE : ST_RD;
				end
				default: begin
					strobe_q <= 1'b0;
					last_q   <= 1'b0;
					state_q  <= ST_IDLE;
				end
			endcase
		end
	end

	`ITOA_ASSERT(a_strobe_src, clk, arst_n, strobe_q |-> ($past(state_q) == ST_SIGN || $past(state_q) == ST_EMIT))
	`ITOA_NEVER(a_rd_idx_zero, clk, arst_n, (state_q == ST_RD) && (idx_q == '0))
	`ITOA_NEVER(a_cnt_range, clk, arst_n, cnt_q > CW'(MAX_DIGITS))
	`ITOA_ASSERT(a_last_ends, clk, arst_n, (strobe_q && last_q) |-> (state_q == ST_IDLE))

endmodule

// ===== design/integer_to_radix_ascii_top.sv =====
// Each request is queued, then the serial divider forms its digits one at a time into the
// digit store; a minus sign, if any, and the digit characters follow, each read from the store.
// Two items queue ahead of the divider; busy marks a full queue. Results cannot be stalled.
// Reset clears control state and sets the radix to ten; the digit store is not cleared.
// ----------------------------------------------------------------------------
// integer_to_radix_ascii_top
// Signed integer to radix text converter, one character per strobe.
// ----------------------------------------------------------------------------
module integer_to_radix_ascii_top
	import itoa_pkg::*;
#(
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
	parameter int MAX_DIGITS  = MAX_DIGITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [VALUE_WIDTH-1:0] number,
	output logic                   busy,
	input  logic                   cfg_valid,
	input  logic [RADIX_W-1:0]     cfg_data,
	output logic                   cfg_ready,
	output logic                   strobe,
	output logic [CHAR_W-1:0]      ascii_char,
	output logic                   last_char
);

	q_status_t            q_status;
	logic                 push;
	logic [VALUE_WIDTH:0] push_data;
	logic                 pop;
	logic [VALUE_WIDTH:0] pop_data;
	logic [RADIX_W-1:0]   radix;

	itoa_front #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.number    (number),
		.busy      (busy),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.cfg_ready (cfg_ready),
		.q_status  (q_status),
		.push      (push),
		.push_data (push_data),
		.radix     (radix)
	);

	itoa_queue #(
		.WIDTH (VALUE_WIDTH + 1),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.status    (q_status)
	);

	itoa_back #(
		.VALUE_WIDTH (VALUE_WIDTH),
		.MAX_DIGITS  (MAX_DIGITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_status   (q_status),
		.pop_data   (pop_data),
		.pop        (pop),
		.radix      (radix),
		.strobe     (strobe),
		.ascii_char (ascii_char),
		.last_char  (last_char)
	);

endmodule

// ===== verif/integer_to_radix_ascii_top_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// integer_to_radix_ascii_top_test
// Self-checking bench for the radix text converter.
// Numbers go in through the start/busy handshake. A local predictor turns
// each accepted request into its expected characters in the current radix,
// and every strobed character is compared against the oldest one pending.
// Directed cases cover decimal, binary and base 36 extremes and radix
// clamping. Random phases then run with different radix settings and idle gaps.
// ----------------------------------------------------------------------------
module integer_to_radix_ascii_top_test;
	import itoa_pkg::*;

	localparam int NUM_W          = 32;
	localparam int MAX_DIGITS     = 32;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int PHASE_ITEMS    = 24;

	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic              last;
	} text_char_t;

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               start     = 1'b0;
	logic [NUM_W-1:0]   number    = '0;
	logic               cfg_valid = 1'b0;
	logic [RADIX_W-1:0] cfg_data  = '0;
	logic               busy;
	logic               cfg_ready;
	logic               strobe;
	logic [CHAR_W-1:0]  ascii_char;
	logic               last_char;

	logic [RADIX_W-1:0] radix_setting = RADIX_RESET;
	text_char_t         expected_text[$];
	int                 error_count = 0;
	int                 idle_cycles = 0;

	integer_to_radix_ascii_top u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.number     (number),
		.busy       (busy),
		.cfg_valid  (cfg_valid),
		.cfg_data   (cfg_data),
		.cfg_ready  (cfg_ready),
		.strobe     (strobe),
		.ascii_char (ascii_char),
		.last_char  (last_char)
	);

	always #5 clk = ~clk;

	// Expected characters for one number in the current radix
	task automatic predict_text(input logic [NUM_W-1:0] value);
		logic [NUM_W-1:0]   magnitude;
		logic [RADIX_W-1:0] digits[MAX_DIGITS];
		logic [RADIX_W-1:0] d;
		int                 count;
		text_char_t         c;
		magnitude = value[NUM_W-1] ? -value : value;
		count = 0;
		do begin
			digits[count] = RADIX_W'(magnitude % radix_setting);
			magnitude = magnitude / radix_setting;
			count++;
		end while (magnitude != 0 && count < MAX_DIGITS);
		if (value[NUM_W-1]) begin
			c.ch = MINUS_CHAR;
			c.last = 1'b0;
			expected_text.push_back(c);
		end
		for (int i = count - 1; i >= 0; i--) begin
			d = digits[i];
			c.ch = (d < DEC_DIGITS) ? ZERO_CHAR + CHAR_W'(d)
				: ALPHA_CHAR + CHAR_W'(d - DEC_DIGITS);
			c.last = (i == 0);
			expected_text.push_back(c);
		end
	endtask

	task automatic send_number(input logic [NUM_W-1:0] value, input int gap);
		start <= 1'b1;
		number <= value;
		do @(posedge clk); while (busy);
		predict_text(value);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain;
		start <= 1'b0;
		while (expected_text.size() != 0) @(posedge clk);
	endtask

	task automatic set_radix(input logic [RADIX_W-1:0] value);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (value < RADIX_MIN)
			radix_setting = RADIX_MIN;
		else if (value > RADIX_MAX)
			radix_setting = RADIX_MAX;
		else
			radix_setting = value;
	endtask

	function automatic int random_gap();
		int r;
		r = $urandom_range(0, 19);
		if (r < 8)
			return 0;
		else if (r < 18)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	function automatic logic [NUM_W-1:0] random_number();
		logic [NUM_W-1:0] v;
		case ($urandom_range(0, 9))
			4, 5: v = $urandom_range(0, 300);
			6: v = $urandom >> $urandom_range(0, NUM_W - 1);
			7: begin
				case ($urandom_range(0, 5))
					0: v = '0;
					1: v = '1;
					2: v = 32'h8000_0000;
					3: v = 32'h7fff_ffff;
					4: v = NUM_W'(radix_setting);
					default: v = NUM_W'(radix_setting) - 1'b1;
				endcase
			end
			default: v = $urandom;
		endcase
		if ($urandom_range(0, 3) == 0)
			v = -v;
		return v;
	endfunction

	task automatic test_decimal_defaults;
		send_number(32'd0, 0);
		send_number(32'd7, 1);
		send_number(-32'sd7, 0);
		send_number(32'h7fff_ffff, 2);
		send_number(32'h8000_0000, 0);
		send_number(32'd1000000000, 0);
		send_number('1, 3);
	endtask

	task automatic test_binary_extremes;
		set_radix(6'd2);
		send_number(32'd0, 0);
		send_number('1, 0);
		send_number(32'h7fff_ffff, 1);
		send_number(32'h8000_0000, 0);
		send_number(32'h5555_5555, 0);
	endtask

	task automatic test_base36_letters;
		set_radix(6'd36);
		send_number(32'd35, 0);
		send_number(32'd36, 0);
		send_number(-32'sd35, 2);
		send_number(32'd1295, 0);
		send_number(32'h7fff_ffff, 0);
		send_number(32'h8000_0000, 0);
	endtask

	task automatic test_radix_clamping;
		set_radix(6'd0);
		send_number(32'd5, 0);
		set_radix(6'd1);
		send_number(-32'sd6, 0);
		set_radix(6'd37);
		send_number(32'd71, 0);
		set_radix(6'd63);
		send_number(-32'sd1295, 0);
	endtask

	// Sender holds off until every pending character is back, then resumes
	task automatic test_drain_pause;
		set_radix(6'd10);
		repeat (5) send_number(random_number(), 0);
		drain();
		repeat (5) send_number(random_number(), random_gap());
	endtask

	task automatic test_random_radices;
		logic [RADIX_W-1:0] settings[8];
		settings = '{6'd2, 6'd36, 6'd16, 6'd8, 6'd3, 6'd0, 6'd0, 6'd0};
		for (int p = 5; p < 8; p++)
			settings[p] = RADIX_W'($urandom_range(0, 63));
		for (int p = 0; p < 8; p++) begin
			set_radix(settings[p]);
			for (int i = 0; i < PHASE_ITEMS; i++)
				send_number(random_number(), (p == 1) ? 0 : random_gap());
		end
	endtask

	always @(posedge clk) begin
		text_char_t c;
		if (arst_n && strobe) begin
			if (expected_text.size() == 0) begin
				$error("unexpected character: ascii_char %h last_char %b",
					ascii_char, last_char);
				error_count++;
			end else begin
				c = expected_text.pop_front();
				if (ascii_char !== c.ch) begin
					$error("ascii_char: expected %h, actual %h", c.ch, ascii_char);
					error_count++;
				end
				if (last_char !== c.last) begin
					$error("last_char: expected %b, actual %b", c.last, last_char);
					error_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || strobe || (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("integer_to_radix_ascii_top_test: errors");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_decimal_defaults();
		test_binary_extremes();
		test_base36_letters();
		test_radix_clamping();
		test_drain_pause();
		test_random_radices();
		drain();
		repeat (40) @(posedge clk);
		if (error_count == 0 && expected_text.size() == 0)
			$display("integer_to_radix_ascii_top_test: clean");
		else
			$display("integer_to_radix_ascii_top_test: errors");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+design
design/itoa_pkg.sv
design/itoa_ram.sv
design/itoa_queue.sv
design/itoa_front.sv
design/itoa_back.sv
design/integer_to_radix_ascii_top.sv
verif/integer_to_radix_ascii_top_test.sv
